// ===== rtl/core/nsbm_pkg.sv =====
// ============================================================================
// nsbm_pkg
// shared types and constants for the nsec type bitmap checker
// ============================================================================
package nsbm_pkg;

    localparam int unsigned MAX_WINDOW_BYTES = 32;

    typedef enum logic [1:0] {
        PH_WINDOW = 2'd0,
        PH_LENGTH = 2'd1,
        PH_MASK   = 2'd2
    } nsbm_phase_t;

    typedef struct packed {
        logic present;
        logic format_error;
    } nsbm_result_t;

endpackage

// ===== rtl/core/nsbm_parse.sv =====
// ============================================================================
// nsbm_parse
// window parser state and per-byte step logic for one bitmap
// ============================================================================
module nsbm_parse
    import nsbm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    input  logic [15:0]  query_type,
    input  logic         last,
    output nsbm_result_t result
);

    nsbm_phase_t phase_reg, phase_next;
    logic        match_reg, match_next;
    logic [5:0]  left_reg, left_next;
    logic [4:0]  index_reg, index_next;
    logic        decided_reg, decided_next;
    logic        bit_reg, bit_next;
    logic        error_reg, error_next;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [5:0]  left_dec;
    logic [2:0]  bit_sel;

    assign hi       = query_type[15:8];
    assign lo       = query_type[7:0];
    assign left_dec = left_reg - 6'd1;
    assign bit_sel  = 3'd7 - lo[2:0];

    always_comb
    begin
        phase_next   = phase_reg;
        match_next   = match_reg;
        left_next    = left_reg;
        index_next   = index_reg;
        decided_next = decided_reg;
        bit_next     = bit_reg;
        error_next   = error_reg;

        if (!decided_reg)
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    if ((data_byte == 8'd0) || (data_byte > 8'(MAX_WINDOW_BYTES)))
                    begin
                        decided_next = 1'b1;
                        error_next   = 1'b1;
                        bit_next     = 1'b0;
                    end
                    else
                    begin
                        left_next  = data_byte[5:0];
                        index_next = '0;
                        bit_next   = 1'b0;
                        phase_next = PH_MASK;
                        if (last)
                        begin
                            decided_next = 1'b1;
                            error_next   = 1'b1;
                        end
                    end
                end
                PH_MASK:
                begin
                    if (match_reg && (index_reg == lo[7:3]))
                    begin
                        bit_next = data_byte[bit_sel];
                    end
                    index_next = index_reg + 5'd1;
                    left_next  = left_dec;
                    if (left_dec == 6'd0)
                    begin
                        phase_next = PH_WINDOW;
                        if (match_reg)
                        begin
                            decided_next = 1'b1;
                        end
                        else
                        begin
                            bit_next = 1'b0;
                        end
                    end
                    else if (last)
                    begin
                        decided_next = 1'b1;
                        error_next   = 1'b1;
                        bit_next     = 1'b0;
                    end
                end
                default:
                begin
                    // unused phase code behaves as window number
                    match_next = (data_byte == hi);
                    phase_next = PH_LENGTH;
                    if (last)
                    begin
                        decided_next = 1'b1;
                        error_next   = 1'b1;
                        bit_next     = 1'b0;
                    end
                end
            endcase
        end

        result.present      = decided_next && !error_next && bit_next;
        result.format_error = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WINDOW;
            match_reg   <= 1'b0;
            left_reg    <= '0;
            index_reg   <= '0;
            decided_reg <= 1'b0;
            bit_reg     <= 1'b0;
            error_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                // bitmap done, back to reset state
                phase_reg   <= PH_WINDOW;
                match_reg   <= 1'b0;
                left_reg    <= '0;
                index_reg   <= '0;
                decided_reg <= 1'b0;
                bit_reg     <= 1'b0;
                error_reg   <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                match_reg   <= match_next;
                left_reg    <= left_next;
                index_reg   <= index_next;
                decided_reg <= decided_next;
                bit_reg     <= bit_next;
                error_reg   <= error_next;
            end
        end
    end

endmodule

// ===== rtl/core/nsec_type_bitmap_check.sv =====
// ============================================================================
// nsec_type_bitmap_check
// nsec type bitmap lookup, one bitmap byte per beat
// ============================================================================
// Takes an nsec type bitmap one byte per input beat, with the queried 16-bit
// type and a last flag, and gives one result beat per bitmap (on its last
// byte): present and format_error. Windows are a window number, a length of
// 1 to 32 and that many mask bytes; the window whose number equals the high
// byte of the type decides the answer from the mask bit of the low byte. A
// bad length or a window cut short by the end of the bitmap raises
// format_error and forces present low. Throughput is one byte per cycle
// unless a last byte waits for a full result slot: each beat is registered
// at the input; as it leaves that register it steps the parser and, on a
// last byte, its result is written into the output register. Only a
// stalled result slot holds back a last byte; other bytes never stall.
// ============================================================================
module nsec_type_bitmap_check
    import nsbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic [15:0] query_type,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        present,
    output logic        format_error
);

    // input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic [15:0] s1_type_reg;
    logic        s1_last_reg;

    // result register
    logic         out_valid_reg;
    nsbm_result_t out_reg;

    logic         out_free;
    logic         s1_advance;
    nsbm_result_t step_result;

    // result slot can take a new beat when empty or being drained
    assign out_free   = !out_valid_reg || out_ready;
    // only a last byte needs room in the result slot
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    nsbm_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_advance),
        .data_byte  (s1_byte_reg),
        .query_type (s1_type_reg),
        .last       (s1_last_reg),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_type_reg <= query_type;
            s1_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_advance && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_advance && s1_last_reg)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign present      = out_reg.present;
    assign format_error = out_reg.format_error;

endmodule

// ===== bench/nsbm_answer_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nsbm_answer_checker
// watches both channels of the nsec type bitmap checker and scores its answers
// ============================================================================
// Keeps a private copy of the window parser, steps it on every accepted input
// beat and queues the expected answer on each last byte. Every accepted result
// beat is compared field by field with the oldest queued answer.
// ============================================================================
module nsbm_answer_checker
    import nsbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       query_type,
    input  logic              last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              present,
    input  logic              format_error,
    output int unsigned       mismatches,
    output int unsigned       answers_due
);

    // parser copy
    nsbm_phase_t  phase;
    logic         in_type_window;
    logic [5:0]   mask_bytes_left;
    logic [4:0]   mask_byte_idx;
    logic         decided;
    logic         type_bit;
    logic         bad_format;

    nsbm_result_t expected_answers[$];
    nsbm_result_t want;

    task automatic restart_parse();
        phase           = PH_WINDOW;
        in_type_window  = 1'b0;
        mask_bytes_left = '0;
        mask_byte_idx   = '0;
        decided         = 1'b0;
        type_bit        = 1'b0;
        bad_format      = 1'b0;
    endtask

    task automatic flag_bad_window();
        decided    = 1'b1;
        bad_format = 1'b1;
        type_bit   = 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] answer check: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parse();
            expected_answers.delete();
            mismatches  = 0;
            answers_due = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (!decided)
                begin
                    case (phase)
                        PH_LENGTH:
                        begin
                            if (data_byte == 8'd0 || data_byte > 8'(MAX_WINDOW_BYTES))
                                flag_bad_window();
                            else
                            begin
                                mask_bytes_left = data_byte[5:0];
                                mask_byte_idx   = '0;
                                type_bit        = 1'b0;
                                phase           = PH_MASK;
                                if (last)
                                    flag_bad_window();
                            end
                        end
                        PH_MASK:
                        begin
                            if (in_type_window && mask_byte_idx == query_type[7:3])
                                type_bit = data_byte[3'd7 - query_type[2:0]];
                            mask_byte_idx   = mask_byte_idx + 5'd1;
                            mask_bytes_left = mask_bytes_left - 6'd1;
                            if (mask_bytes_left == 6'd0)
                            begin
                                phase = PH_WINDOW;
                                if (in_type_window)
                                    decided = 1'b1;
                                else
                                    type_bit = 1'b0;
                            end
                            else if (last)
                                flag_bad_window();
                        end
                        default:
                        begin
                            in_type_window = (data_byte == query_type[15:8]);
                            phase          = PH_LENGTH;
                            if (last)
                                flag_bad_window();
                        end
                    endcase
                end
                if (last)
                begin
                    want.present      = decided && !bad_format && type_bit;
                    want.format_error = bad_format;
                    expected_answers.push_back(want);
                    restart_parse();
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("result beat with no bitmap pending");
                else
                begin
                    want = expected_answers.pop_front();
                    if (present !== want.present)
                        report_mismatch($sformatf("present %b, want %b",
                                                  present, want.present));
                    if (format_error !== want.format_error)
                        report_mismatch($sformatf("format_error %b, want %b",
                                                  format_error, want.format_error));
                end
            end

            answers_due = expected_answers.size();
        end
    end

endmodule

// ===== bench/nsec_type_bitmap_check_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nsec_type_bitmap_check_test
// stimulus and verdict for the nsec type bitmap checker
// ============================================================================
// Feeds whole type bitmaps byte by byte: a short directed set covering every
// way a parse can end, then random bitmaps, mostly well formed with random
// windows and masks, the rest truncated, carrying bad lengths or plain noise.
// Both channels stall at random; the checker beside the block scores results.
// ============================================================================
module nsec_type_bitmap_check_test
    import nsbm_pkg::*;
();

    localparam int unsigned BYTE_TARGET = 1050;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic [15:0] query_type;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic        present;
    logic        format_error;

    int unsigned mismatches;
    int unsigned answers_due;
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;

    // bitmap under construction and the type it is searched for
    logic [7:0]  bitmap[$];
    logic [15:0] bitmap_type;
    // calm: no idle cycles on either side for this bitmap
    // wobble: query_type may change from byte to byte
    bit          calm = 1'b0;
    bit          wobble = 1'b0;

    nsec_type_bitmap_check u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .query_type   (query_type),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .present      (present),
        .format_error (format_error)
    );

    nsbm_answer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .query_type   (query_type),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .present      (present),
        .format_error (format_error),
        .mismatches   (mismatches),
        .answers_due  (answers_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // send the bitmap queue, one beat per byte, last on the final byte
    task automatic send_bitmap();
        int gap;
        int i;
        for (i = 0; i < bitmap.size(); i++)
        begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid   <= 1'b1;
            data_byte  <= bitmap[i];
            query_type <= (wobble && $urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : bitmap_type;
            last       <= (i == bitmap.size() - 1);
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
            bytes_sent++;
        end
    endtask

    // random bitmap: windows with random masks, sometimes broken or pure noise
    task automatic build_random_bitmap();
        int         kind;
        int         nwin;
        int         len;
        int         cut;
        int         w;
        logic [7:0] wnum;
        bit         match;
        kind = $urandom_range(0, 9);
        bitmap.delete();
        bitmap_type = 16'($urandom);
        wobble = 1'b0;
        if (kind == 9)
        begin
            // noise, with the queried type drifting under it
            wobble = 1'b1;
            repeat ($urandom_range(1, 8)) bitmap.push_back(8'($urandom));
        end
        else
        begin
            if (kind == 8)
            begin
                // bad length up front, the rest is ignored after the decision
                bitmap.push_back(8'($urandom));
                case ($urandom_range(0, 2))
                    0: bitmap.push_back(8'd0);
                    1: bitmap.push_back(8'(MAX_WINDOW_BYTES + 1));
                    default: bitmap.push_back(8'($urandom_range(34, 255)));
                endcase
            end
            nwin = $urandom_range(1, 3);
            for (w = 0; w < nwin; w++)
            begin
                match = $urandom_range(0, 1);
                wnum  = match ? bitmap_type[15:8] : 8'($urandom);
                // mostly short windows, a few long ones up to the maximum
                len   = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 32)
                                                     : $urandom_range(1, 4);
                // usually aim the low byte inside the matching window
                if (match && $urandom_range(0, 3) != 0)
                    bitmap_type[7:3] = 5'($urandom_range(0, len - 1));
                bitmap.push_back(wnum);
                bitmap.push_back(8'(len));
                repeat (len) bitmap.push_back(8'($urandom));
            end
            if (kind == 7)
            begin
                // cut short at a random byte
                cut = $urandom_range(1, bitmap.size() - 1);
                while (bitmap.size() > cut)
                    void'(bitmap.pop_back());
            end
        end
    endtask

    // result side: random stall before each result beat
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'd0;
        query_type = 16'd0;
        last       = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // type in window 1, bit set, trailing byte ignored after the decision
        bitmap = '{8'h01, 8'h01, 8'h80, 8'hee};
        bitmap_type = 16'h0100;
        send_bitmap();
        // ends right after a window number
        bitmap = '{8'h00};
        bitmap_type = 16'h0000;
        send_bitmap();
        // ends right after a length byte
        bitmap = '{8'h00, 8'h02};
        send_bitmap();
        // ends inside the mask bytes
        bitmap = '{8'h00, 8'h03, 8'hff};
        send_bitmap();
        // zero length
        bitmap = '{8'h00, 8'h00, 8'h12};
        send_bitmap();
        // length one past the maximum
        bitmap = '{8'h05, 8'h21, 8'haa};
        bitmap_type = 16'h0500;
        send_bitmap();
        // matching window too short for the low byte
        bitmap = '{8'hff, 8'h01, 8'hff};
        bitmap_type = 16'hffff;
        send_bitmap();
        // no matching window at all
        bitmap = '{8'h02, 8'h01, 8'hff};
        bitmap_type = 16'h0000;
        send_bitmap();

        while (bytes_sent < BYTE_TARGET)
        begin
            calm = ($urandom_range(0, 7) == 0);
            build_random_bitmap();
            send_bitmap();
        end
        in_valid <= 1'b0;
        last     <= 1'b0;

        // drain, then watch for anything stray before the verdict
        wait (answers_due == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/nsbm_pkg.sv
rtl/core/nsbm_parse.sv
rtl/core/nsec_type_bitmap_check.sv
bench/nsbm_answer_checker.sv
bench/nsec_type_bitmap_check_test.sv
